FILE: rtl/core/qalu_pkg.sv
// Shared constants for the quaternion ALU: opcodes, component indexes and the
// Hamilton product term tables used by every multiply lane.
// No dependencies.
`default_nettype none

package qalu_pkg;

   // Operation codes carried in the opcode field.
   localparam logic [2:0] OP_ADD      = 3'd0;
   localparam logic [2:0] OP_SUB      = 3'd1;
   localparam logic [2:0] OP_CONJ     = 3'd2;
   localparam logic [2:0] OP_PRODUCT  = 3'd3;
   localparam logic [2:0] OP_SCALE    = 3'd4;
   localparam logic [2:0] OP_SANDWICH = 3'd5;

   // A quaternion has four components, and each output component of a
   // Hamilton product is a sum of four terms.
   localparam int unsigned NUM_LANES = 4;
   localparam int unsigned NUM_TERMS = 4;

   typedef logic [1:0] comp_idx_type;

   // Component order is x, y, z, w; w is the real part.
   localparam comp_idx_type COMP_W = 2'd3;

   // Term j of every output component multiplies a[HAM_A_IDX[j]] by
   // b[HAM_B_IDX[k][j]], negated where HAM_NEG[k][j] is set.
   localparam comp_idx_type HAM_A_IDX [NUM_TERMS] = '{2'd3, 2'd0, 2'd1, 2'd2};

   localparam comp_idx_type HAM_B_IDX [NUM_LANES][NUM_TERMS] = '{
      '{2'd0, 2'd3, 2'd2, 2'd1},
      '{2'd1, 2'd2, 2'd3, 2'd0},
      '{2'd2, 2'd1, 2'd0, 2'd3},
      '{2'd3, 2'd0, 2'd1, 2'd2}
   };

   localparam logic HAM_NEG [NUM_LANES][NUM_TERMS] = '{
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0},
      '{1'b0, 1'b1, 1'b1, 1'b1}
   };

endpackage

`default_nettype wire

FILE: rtl/core/qalu_lane.sv
// One multiply lane of the quaternion ALU: four signed products, then their
// exact sum rounded to nearest and saturated. Two register stages.
// Depends on qalu_pkg.
`default_nettype none

module qalu_lane
   import qalu_pkg::*;
#(
   parameter int W = 16,
   parameter int F = 12
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W-1:0] op_x [NUM_TERMS],
   input  logic signed [W:0]   op_y [NUM_TERMS],
   input  logic [NUM_TERMS-1:0] neg,
   output logic signed [W-1:0] res,
   output logic                res_sat
);

   localparam int PW = 2 * W + 1;
   localparam int SW = 2 * W + 4;

   logic signed [PW-1:0] prod_in [NUM_TERMS];
   logic signed [PW-1:0] prod_ff [NUM_TERMS];
   logic [NUM_TERMS-1:0] neg_ff;
   logic signed [SW-1:0] acc;
   logic signed [SW-1:0] scaled;
   logic                 ovf;
   logic signed [W-1:0]  res_in;
   logic signed [W-1:0]  res_ff;
   logic                 res_sat_ff;

   always_comb begin
      for (int j = 0; j < NUM_TERMS; j++) begin
         prod_in[j] = PW'(op_x[j]) * PW'(op_y[j]);
      end
   end

   // Half an LSB is added before the floor shift, so ties go upwards.
   always_comb begin
      acc = SW'(1) <<< (F - 1);
      for (int j = 0; j < NUM_TERMS; j++) begin
         if (neg_ff[j]) begin
            acc = acc - SW'(prod_ff[j]);
         end else begin
            acc = acc + SW'(prod_ff[j]);
         end
      end
      scaled = acc >>> F;
      ovf    = (scaled[SW-1:W-1] != '0) && (scaled[SW-1:W-1] != '1);
      if (ovf) begin
         res_in = scaled[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         res_in = scaled[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         neg_ff     <= neg;
         res_ff     <= res_in;
         res_sat_ff <= ovf;
      end
   end

   assign res     = res_ff;
   assign res_sat = res_sat_ff;

endmodule

`default_nettype wire

FILE: rtl/core/qalu_merge.sv
// Merging logic of the quaternion ALU: the element-wise operations and the
// selection between them and the first product lanes, with the clip flag.
// Depends on qalu_pkg.
`default_nettype none

module qalu_merge
   import qalu_pkg::*;
#(
   parameter int W = 16
) (
   input  logic [2:0]            opcode,
   input  logic signed [W-1:0]   a [NUM_LANES],
   input  logic signed [W-1:0]   b [NUM_LANES],
   input  logic signed [W-1:0]   lane_res [NUM_LANES],
   input  logic [NUM_LANES-1:0]  lane_sat,
   output logic signed [W-1:0]   res [NUM_LANES],
   output logic                  res_sat
);

   // Returns the clip flag above a value saturated to W bits.
   function automatic logic [W:0] sat_narrow(input logic signed [W:0] v);
      if (v[W] != v[W-1]) begin
         return {1'b1, v[W], {(W-1){~v[W]}}};
      end
      return {1'b0, v[W-1:0]};
   endfunction

   logic signed [W:0] wide [NUM_LANES];
   logic [W:0]        packed_res [NUM_LANES];

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         wide[k] = '0;
      end
      case (opcode)
         OP_ADD: begin
            for (int k = 0; k < NUM_LANES; k++) begin
               wide[k] = (W+1)'(a[k]) + (W+1)'(b[k]);
            end
         end
         OP_SUB: begin
            for (int k = 0; k < NUM_LANES; k++) begin
               wide[k] = (W+1)'(a[k]) - (W+1)'(b[k]);
            end
         end
         OP_CONJ: begin
            for (int k = 0; k < NUM_LANES; k++) begin
               if (k == int'(COMP_W)) begin
                  wide[k] = (W+1)'(a[k]);
               end else begin
                  wide[k] = -(W+1)'(a[k]);
               end
            end
         end
         default: begin
            for (int k = 0; k < NUM_LANES; k++) begin
               wide[k] = '0;
            end
         end
      endcase
      for (int k = 0; k < NUM_LANES; k++) begin
         packed_res[k] = sat_narrow(wide[k]);
      end
   end

   always_comb begin
      res_sat = 1'b0;
      for (int k = 0; k < NUM_LANES; k++) begin
         res[k] = '0;
      end
      case (opcode)
         OP_ADD, OP_SUB, OP_CONJ: begin
            for (int k = 0; k < NUM_LANES; k++) begin
               res[k]  = packed_res[k][W-1:0];
               res_sat = res_sat | packed_res[k][W];
            end
         end
         OP_PRODUCT, OP_SCALE, OP_SANDWICH: begin
            for (int k = 0; k < NUM_LANES; k++) begin
               res[k] = lane_res[k];
            end
            res_sat = |lane_sat;
         end
         default: begin
            res_sat = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/quaternion_alu_core.sv
// Quaternion ALU, fully pipelined: add, subtract, conjugate, Hamilton product,
// scale and the rotation sandwich a*b*conj(a), in signed fixed point.
// An item passes through the input register, stages 1 to 4 and the output register.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits for rsp_ready. Synchronous active-high reset empties the pipeline.
`default_nettype none

module quaternion_alu_core
   import qalu_pkg::*;
#(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRAC_BITS       = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_opcode,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_w,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_w,
   input  logic signed [COMPONENT_WIDTH-1:0] req_scale,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_z,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_w,
   output logic                              rsp_saturated
);

   localparam int W = COMPONENT_WIDTH;

   // The pipeline runs as one: every stage moves on whenever the output
   // register is empty or its result is being transferred this cycle. A new
   // input transfer is therefore taken in every cycle that the output moves.
   // While reset is high nothing is taken, so ready stays low.
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en && !reset;

   // Stage 0: the input register.
   logic                v0_ff, v0_in;
   logic [2:0]          op0_ff;
   logic signed [W-1:0] a0_ff [NUM_LANES];
   logic signed [W-1:0] b0_ff [NUM_LANES];
   logic signed [W-1:0] s0_ff;

   // Stages 1 and 2 carry the operands beside the first product lanes.
   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0]          op1_ff, op2_ff, op3_ff, op4_ff;
   logic signed [W-1:0] a1_ff [NUM_LANES];
   logic signed [W-1:0] b1_ff [NUM_LANES];
   logic signed [W-1:0] a2_ff [NUM_LANES];
   logic signed [W-1:0] b2_ff [NUM_LANES];

   // Stages 3 and 4 carry the merged early result beside the second lanes.
   logic signed [W-1:0] early [NUM_LANES];
   logic                early_sat;
   logic signed [W-1:0] early3_ff [NUM_LANES];
   logic signed [W-1:0] early4_ff [NUM_LANES];
   logic                esat3_ff, esat4_ff;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] rsp_r_ff [NUM_LANES];
   logic                rsp_sat_ff;

   // Lane operands and results.
   logic signed [W-1:0]  x1 [NUM_LANES][NUM_TERMS];
   logic signed [W:0]    y1 [NUM_LANES][NUM_TERMS];
   logic [NUM_TERMS-1:0] neg1 [NUM_LANES];
   logic signed [W-1:0]  tmp [NUM_LANES];
   logic [NUM_LANES-1:0] tmp_sat;

   logic signed [W:0]    ac [NUM_LANES];
   logic signed [W-1:0]  x2 [NUM_LANES][NUM_TERMS];
   logic signed [W:0]    y2 [NUM_LANES][NUM_TERMS];
   logic [NUM_TERMS-1:0] neg2 [NUM_LANES];
   logic signed [W-1:0]  r2 [NUM_LANES];
   logic [NUM_LANES-1:0] r2_sat;

   assign v0_in        = req_valid;
   assign rsp_valid_in = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v0_ff        <= v0_in;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset; they only matter alongside a valid bit.
   always_ff @(posedge clock) begin
      if (en) begin
         op0_ff   <= req_opcode;
         a0_ff[0] <= req_a_x;
         a0_ff[1] <= req_a_y;
         a0_ff[2] <= req_a_z;
         a0_ff[3] <= req_a_w;
         b0_ff[0] <= req_b_x;
         b0_ff[1] <= req_b_y;
         b0_ff[2] <= req_b_z;
         b0_ff[3] <= req_b_w;
         s0_ff    <= req_scale;

         op1_ff <= op0_ff;
         a1_ff  <= a0_ff;
         b1_ff  <= b0_ff;
         op2_ff <= op1_ff;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;

         op3_ff    <= op2_ff;
         early3_ff <= early;
         esat3_ff  <= early_sat;
         op4_ff    <= op3_ff;
         early4_ff <= early3_ff;
         esat4_ff  <= esat3_ff;
      end
   end

   // First lane bank: the Hamilton product a*b, or for a scale each lane takes
   // its own component of a times the scalar in its first term slot.
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         for (int j = 0; j < NUM_TERMS; j++) begin
            if (op0_ff == OP_SCALE) begin
               x1[k][j]   = (j == 0) ? a0_ff[k] : '0;
               y1[k][j]   = (j == 0) ? (W+1)'(s0_ff) : '0;
               neg1[k][j] = 1'b0;
            end else begin
               x1[k][j]   = a0_ff[HAM_A_IDX[j]];
               y1[k][j]   = (W+1)'(b0_ff[HAM_B_IDX[k][j]]);
               neg1[k][j] = HAM_NEG[k][j];
            end
         end
      end
   end

   // Second lane bank: the rounded intermediate times conj(a). The conjugate
   // keeps one extra bit, so negating the most negative value is exact.
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         if (k == int'(COMP_W)) begin
            ac[k] = (W+1)'(a2_ff[k]);
         end else begin
            ac[k] = -(W+1)'(a2_ff[k]);
         end
      end
      for (int k = 0; k < NUM_LANES; k++) begin
         for (int j = 0; j < NUM_TERMS; j++) begin
            x2[k][j]   = tmp[HAM_A_IDX[j]];
            y2[k][j]   = ac[HAM_B_IDX[k][j]];
            neg2[k][j] = HAM_NEG[k][j];
         end
      end
   end

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      qalu_lane #(
         .W (W),
         .F (FRAC_BITS)
      ) u_first (
         .clock   (clock),
         .en      (en),
         .op_x    (x1[k]),
         .op_y    (y1[k]),
         .neg     (neg1[k]),
         .res     (tmp[k]),
         .res_sat (tmp_sat[k])
      );

      qalu_lane #(
         .W (W),
         .F (FRAC_BITS)
      ) u_second (
         .clock   (clock),
         .en      (en),
         .op_x    (x2[k]),
         .op_y    (y2[k]),
         .neg     (neg2[k]),
         .res     (r2[k]),
         .res_sat (r2_sat[k])
      );
   end

   // The element-wise operations and the first lane bank meet here, in step
   // with stage 2. For the sandwich only the clip flag of the intermediate
   // is kept from this point.
   qalu_merge #(
      .W (W)
   ) u_merge (
      .opcode   (op2_ff),
      .a        (a2_ff),
      .b        (b2_ff),
      .lane_res (tmp),
      .lane_sat (tmp_sat),
      .res      (early),
      .res_sat  (early_sat)
   );

   // Output register: the sandwich takes the second lane bank, every other
   // operation the early result that travelled alongside it.
   always_ff @(posedge clock) begin
      if (en) begin
         if (op4_ff == OP_SANDWICH) begin
            rsp_r_ff   <= r2;
            rsp_sat_ff <= esat4_ff | (|r2_sat);
         end else begin
            rsp_r_ff   <= early4_ff;
            rsp_sat_ff <= esat4_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_r_x       = rsp_r_ff[0];
   assign rsp_r_y       = rsp_r_ff[1];
   assign rsp_r_z       = rsp_r_ff[2];
   assign rsp_r_w       = rsp_r_ff[3];
   assign rsp_saturated = rsp_sat_ff;

endmodule

`default_nettype wire

FILE: tb/sv/quaternion_alu_core_test.sv
// Self-checking testbench for quaternion_alu_core: directed and random items,
// predicted in fixed point and checked against every result transfer.
// Depends on qalu_pkg and the quaternion_alu_core RTL.
`timescale 1ns / 1ps

module quaternion_alu_core_test
   import qalu_pkg::*;
();

   localparam int CW = 16;
   localparam int FB = 12;

   // Range of one component after saturation.
   localparam longint COMP_MAX = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint COMP_MIN = -COMP_MAX - 1;

   // Codes the block leaves unused; they must give an all-zero result.
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   // Handy Q4.12 values.
   localparam int Q_ONE = 4096;
   localparam int Q_MAX = 32767;
   localparam int Q_MIN = -32768;

   typedef struct packed {
      logic [2:0]           opcode;
      logic signed [CW-1:0] a_x, a_y, a_z, a_w;
      logic signed [CW-1:0] b_x, b_y, b_z, b_w;
      logic signed [CW-1:0] scale;
   } quat_req_type;

   typedef struct packed {
      logic signed [CW-1:0] r_x, r_y, r_z, r_w;
      logic                 saturated;
   } quat_rsp_type;

   // Components widened for exact intermediate arithmetic.
   typedef struct {
      longint x, y, z, w;
   } wide_quat_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_ready;
   logic [2:0]           req_opcode = '0;
   logic signed [CW-1:0] req_a_x    = '0;
   logic signed [CW-1:0] req_a_y    = '0;
   logic signed [CW-1:0] req_a_z    = '0;
   logic signed [CW-1:0] req_a_w    = '0;
   logic signed [CW-1:0] req_b_x    = '0;
   logic signed [CW-1:0] req_b_y    = '0;
   logic signed [CW-1:0] req_b_z    = '0;
   logic signed [CW-1:0] req_b_w    = '0;
   logic signed [CW-1:0] req_scale  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready  = 1'b0;
   logic signed [CW-1:0] rsp_r_x;
   logic signed [CW-1:0] rsp_r_y;
   logic signed [CW-1:0] rsp_r_z;
   logic signed [CW-1:0] rsp_r_w;
   logic                 rsp_saturated;

   // Results predicted for accepted requests, oldest first.
   quat_rsp_type pending_results [$];
   int           error_count = 0;
   // When clear, neither side inserts idle cycles.
   bit           idle_on     = 1'b1;
   int           stall_left  = 0;

   quaternion_alu_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_a_x       (req_a_x),
      .req_a_y       (req_a_y),
      .req_a_z       (req_a_z),
      .req_a_w       (req_a_w),
      .req_b_x       (req_b_x),
      .req_b_y       (req_b_y),
      .req_b_z       (req_b_z),
      .req_b_w       (req_b_w),
      .req_scale     (req_scale),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_r_x       (rsp_r_x),
      .rsp_r_y       (rsp_r_y),
      .rsp_r_z       (rsp_r_z),
      .rsp_r_w       (rsp_r_w),
      .rsp_saturated (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A hung handshake must not run forever; this is far beyond the slowest
   // legitimate run, even with every idle burst at its longest.
   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Clips a value to the component range and notes whether it was clipped.
   function automatic longint clip_component(input longint v, inout bit clipped);
      if (v > COMP_MAX) begin
         clipped = 1'b1;
         return COMP_MAX;
      end
      if (v < COMP_MIN) begin
         clipped = 1'b1;
         return COMP_MIN;
      end
      return v;
   endfunction

   // The sum carries 2*FB fraction bits. Adding half an LSB and then taking
   // the floor rounds to nearest with ties towards plus infinity.
   function automatic longint round_clip(input longint sum, inout bit clipped);
      longint v;
      v = (sum + (64'sd1 <<< (FB - 1))) >>> FB;
      return clip_component(v, clipped);
   endfunction

   // Hamilton product p*q, each component rounded and clipped once.
   function automatic wide_quat_type hamilton_round(input wide_quat_type p,
                                                    input wide_quat_type q,
                                                    inout bit clipped);
      wide_quat_type r;
      r.x = round_clip(p.w * q.x + p.x * q.w + p.y * q.z - p.z * q.y, clipped);
      r.y = round_clip(p.w * q.y - p.x * q.z + p.y * q.w + p.z * q.x, clipped);
      r.z = round_clip(p.w * q.z + p.x * q.y - p.y * q.x + p.z * q.w, clipped);
      r.w = round_clip(p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z, clipped);
      return r;
   endfunction

   function automatic quat_rsp_type quat_alu_predict(input quat_req_type it);
      wide_quat_type a, b, r, mid, a_conj;
      longint        s;
      bit            clipped;
      quat_rsp_type  res;
      clipped = 1'b0;
      a.x = longint'(it.a_x);
      a.y = longint'(it.a_y);
      a.z = longint'(it.a_z);
      a.w = longint'(it.a_w);
      b.x = longint'(it.b_x);
      b.y = longint'(it.b_y);
      b.z = longint'(it.b_z);
      b.w = longint'(it.b_w);
      s   = longint'(it.scale);
      r.x = 0;
      r.y = 0;
      r.z = 0;
      r.w = 0;
      case (it.opcode)
         OP_ADD: begin
            r.x = clip_component(a.x + b.x, clipped);
            r.y = clip_component(a.y + b.y, clipped);
            r.z = clip_component(a.z + b.z, clipped);
            r.w = clip_component(a.w + b.w, clipped);
         end
         OP_SUB: begin
            r.x = clip_component(a.x - b.x, clipped);
            r.y = clip_component(a.y - b.y, clipped);
            r.z = clip_component(a.z - b.z, clipped);
            r.w = clip_component(a.w - b.w, clipped);
         end
         OP_CONJ: begin
            r.x = clip_component(-a.x, clipped);
            r.y = clip_component(-a.y, clipped);
            r.z = clip_component(-a.z, clipped);
            r.w = a.w;
         end
         OP_PRODUCT: begin
            r = hamilton_round(a, b, clipped);
         end
         OP_SCALE: begin
            r.x = round_clip(a.x * s, clipped);
            r.y = round_clip(a.y * s, clipped);
            r.z = round_clip(a.z * s, clipped);
            r.w = round_clip(a.w * s, clipped);
         end
         OP_SANDWICH: begin
            // The intermediate is rounded and clipped; the conjugate keeps
            // its exact negated values, one bit wider than a component.
            mid      = hamilton_round(a, b, clipped);
            a_conj.x = -a.x;
            a_conj.y = -a.y;
            a_conj.z = -a.z;
            a_conj.w = a.w;
            r        = hamilton_round(mid, a_conj, clipped);
         end
         default: begin
         end
      endcase
      res.r_x       = CW'(r.x);
      res.r_y       = CW'(r.y);
      res.r_z       = CW'(r.z);
      res.r_w       = CW'(r.w);
      res.saturated = clipped;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   function automatic quat_req_type make_item(input logic [2:0] op,
                                              input int ax, input int ay, input int az,
                                              input int aw, input int bx, input int by,
                                              input int bz, input int bw, input int s);
      quat_req_type it;
      it.opcode = op;
      it.a_x    = CW'(ax);
      it.a_y    = CW'(ay);
      it.a_z    = CW'(az);
      it.a_w    = CW'(aw);
      it.b_x    = CW'(bx);
      it.b_y    = CW'(by);
      it.b_z    = CW'(bz);
      it.b_w    = CW'(bw);
      it.scale  = CW'(s);
      return it;
   endfunction

   // Presents one request and returns at the edge of its transfer. Valid is
   // left high so that a following request can go out back to back; it is
   // only lowered ahead of an idle burst, or by the caller at the very end.
   task automatic send_item(input quat_req_type it);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= it.opcode;
      req_a_x    <= it.a_x;
      req_a_y    <= it.a_y;
      req_a_z    <= it.a_z;
      req_a_w    <= it.a_w;
      req_b_x    <= it.b_x;
      req_b_y    <= it.b_y;
      req_b_z    <= it.b_z;
      req_b_w    <= it.b_w;
      req_scale  <= it.scale;
      do
         @(posedge clock);
      while (!req_ready);
      pending_results.push_back(quat_alu_predict(it));
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [CW-1:0] want,
                              input logic [CW-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      quat_rsp_type want;
      if (pending_results.size() == 0) begin
         error_count++;
         $display("%0t: result transfer with nothing expected, expected none actual %h %h %h %h %b",
                  $time, rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_saturated);
      end else begin
         want = pending_results.pop_front();
         check_field("r_x", want.r_x, rsp_r_x);
         check_field("r_y", want.r_y, rsp_r_y);
         check_field("r_z", want.r_z, rsp_r_z);
         check_field("r_w", want.r_w, rsp_r_w);
         check_field("saturated", {{(CW-1){1'b0}}, want.saturated},
                     {{(CW-1){1'b0}}, rsp_saturated});
      end
   endtask

   // Checks each result transfer and throttles rsp_ready in random bursts.
   // Values are sampled at the edge, before any update that the edge causes.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         check_result();
      if (stall_left != 0)
         stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 17);
      rsp_ready <= (stall_left == 0);
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Sums and differences at the ends of the range, clipped both ways.
   task automatic test_add_sub();
      send_item(make_item(OP_ADD, Q_MAX, Q_MIN, 0, -1, Q_MAX, Q_MIN, 0, 1, 0));
      send_item(make_item(OP_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, -1, 1, Q_MAX));
      send_item(make_item(OP_SUB, Q_MIN, Q_MAX, 0, Q_ONE, Q_MAX, Q_MIN, Q_MIN, Q_ONE, 0));
      send_item(make_item(OP_SUB, 100, -100, Q_MAX, Q_MIN, 50, -50, -1, 1, Q_MIN));
      send_item(make_item(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // Negating the most negative component clips; the real part passes as is.
   task automatic test_conjugate();
      send_item(make_item(OP_CONJ, Q_MIN, Q_MAX, -1, Q_MIN, 0, 0, 0, 0, 0));
      send_item(make_item(OP_CONJ, 1, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 7, 7, Q_MAX));
      send_item(make_item(OP_CONJ, Q_ONE, -Q_ONE, 0, Q_ONE, 0, 0, 0, 0, 0));
   endtask

   // Identity product, rounding ties of both signs, and full clipping.
   task automatic test_product();
      send_item(make_item(OP_PRODUCT, 0, 0, 0, Q_ONE, 1234, -567, Q_MAX, Q_MIN, 0));
      send_item(make_item(OP_PRODUCT, 0, 0, 0, 1, 2048, -2048, 6144, -6144, 0));
      send_item(make_item(OP_PRODUCT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                          Q_MIN, 0));
      send_item(make_item(OP_PRODUCT, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN,
                          Q_MAX, Q_MAX));
   endtask

   // Scaling by one, by one half, and the most negative square.
   task automatic test_scale();
      send_item(make_item(OP_SCALE, 1, -1, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_ONE));
      send_item(make_item(OP_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, 2048));
      send_item(make_item(OP_SCALE, Q_MIN, Q_MAX, 0, -Q_ONE, 0, 0, 0, 0, Q_MIN));
   endtask

   // A quarter turn about z, the identity rotation, and a clipped intermediate.
   task automatic test_sandwich();
      send_item(make_item(OP_SANDWICH, 0, 0, 2896, 2896, Q_ONE, 0, 0, 0, 0));
      send_item(make_item(OP_SANDWICH, 0, 0, 0, Q_ONE, 1000, -2000, 3000, 0, 0));
      send_item(make_item(OP_SANDWICH, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN,
                          Q_MIN, 0));
   endtask

   // The two unused codes give zero whatever the operands.
   task automatic test_unused_opcodes();
      send_item(make_item(OP_UNUSED_6, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                          Q_MIN, Q_MAX));
      send_item(make_item(OP_UNUSED_7, Q_MIN, Q_MAX, -1, 1, -1, 1, Q_MIN, Q_MAX, Q_MIN));
   endtask

   // Components are mostly near unit size, so that products keep their
   // rounding visible, with full-range values and the extremes mixed in.
   function automatic logic signed [CW-1:0] random_component();
      int v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = Q_MAX;
               1: v = Q_MIN;
               2: v = 0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         1, 2, 3: v = int'($urandom);
         default: v = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
      endcase
      return CW'(v);
   endfunction

   task automatic test_random(input int count);
      quat_req_type it;
      int           pick;
      for (int i = 0; i < count; i++) begin
         // Idling is switched per block of items; the last part runs flat out.
         if (i % 100 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         if (i >= count - 150)
            idle_on = 1'b0;
         pick = $urandom_range(0, 19);
         if (pick < 18)
            it.opcode = 3'(pick % 6);
         else
            it.opcode = (pick == 18) ? OP_UNUSED_6 : OP_UNUSED_7;
         it.a_x   = random_component();
         it.a_y   = random_component();
         it.a_z   = random_component();
         it.a_w   = random_component();
         it.b_x   = random_component();
         it.b_y   = random_component();
         it.b_z   = random_component();
         it.b_w   = random_component();
         it.scale = random_component();
         send_item(it);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_add_sub();
      test_conjugate();
      test_product();
      test_scale();
      test_sandwich();
      test_unused_opcodes();
      test_random(900);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      // Give a stray late result the chance to show itself.
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
